// ===== hdl/bounded_sorted_insert_stack_top_macros.svh =====
// Assertion macros used by the sorted insert stack checker.
`ifndef BOUNDED_SORTED_INSERT_STACK_TOP_MACROS_SVH
`define BOUNDED_SORTED_INSERT_STACK_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define BSIS_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define BSIS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/bsis_pkg.sv =====
// Package: sizes, codes and control structs of the sorted insert stack.
`timescale 1ns / 1ps
package bsis_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_PEEK   = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic insert;      // compare-and-shift all cells with the input value
    logic emit_empty;  // report an empty store
    logic emit_read;   // report the entry at the read address
    logic read_last;   // mark the reported entry as the final beat
    logic use_idx;     // read address from the dump index, else the top
    logic load_idx;    // dump index <= entry below the top
    logic dec_idx;     // dump index steps down
  } bsis_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;
    logic single;
    logic idx_zero;
  } bsis_stat_t;

endpackage

// ===== hdl/bsis_ctrl.sv =====
// Controller: command decode and dump sequencing for the sorted insert stack.
`timescale 1ns / 1ps
module bsis_ctrl import bsis_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           command_i,
  input  bsis_stat_t           stat_i,
  output bsis_cmd_t            cmd_o,
  output logic                 busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (command_i)
            CMD_INSERT: begin
              cmd_o.insert = 1'b1;
            end
            CMD_PEEK: begin
              if (stat_i.empty) begin
                cmd_o.emit_empty = 1'b1;
              end else begin
                cmd_o.emit_read = 1'b1;
                cmd_o.read_last = 1'b1;
              end
            end
            CMD_DUMP: begin
              if (stat_i.empty) begin
                cmd_o.emit_empty = 1'b1;
              end else begin
                cmd_o.emit_read = 1'b1;
                cmd_o.read_last = stat_i.single;
                if (!stat_i.single) begin
                  cmd_o.load_idx = 1'b1;
                  state_d        = ST_DUMP;
                end
              end
            end
            default: begin
              // unused code: drop the item
            end
          endcase
        end
      end
      ST_DUMP: begin
        busy_o          = 1'b1;
        cmd_o.emit_read = 1'b1;
        cmd_o.use_idx   = 1'b1;
        cmd_o.read_last = stat_i.idx_zero;
        if (stat_i.idx_zero) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.dec_idx = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/bsis_dpath.sv =====
// Datapath: row of compare-and-shift cells, entry count, dump index, result register.
`timescale 1ns / 1ps
module bsis_dpath import bsis_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bsis_cmd_t                    cmd_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output bsis_stat_t                   stat_o,
  output logic                         result_strobe_o,
  output logic signed [DATA_WIDTH-1:0] result_value_o,
  output logic [1:0]                   status_o,
  output logic                         last_o
);

  logic signed [DATA_WIDTH-1:0] store_q [DEPTH];
  logic signed [DATA_WIDTH-1:0] new_val [DEPTH];
  logic [DEPTH-1:0]             ge;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [CNT_W-1:0]             cnt_m1, cnt_m2;
  logic [IDX_W-1:0]             idx_q, idx_d;
  logic [IDX_W-1:0]             rd_addr;
  logic signed [DATA_WIDTH-1:0] rd_data;
  logic                         full;
  logic signed [DATA_WIDTH-1:0] discard;

  logic                         strobe_q, strobe_d;
  logic signed [DATA_WIDTH-1:0] value_q, value_d;
  status_e                      status_q, status_d;
  logic                         last_q, last_d;

  assign full   = (count_q == CNT_W'(DEPTH));
  assign cnt_m1 = count_q - CNT_W'(1);
  assign cnt_m2 = count_q - CNT_W'(2);

  // Each cell: free slot or holds a larger value means it moves up.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (CNT_W'(i) >= count_q) || (store_q[i] > value_i);
    end
    new_val[0] = ge[0] ? value_i : store_q[0];
    for (int i = 1; i < DEPTH; i++) begin
      new_val[i] = ge[i] ? (ge[i-1] ? store_q[i-1] : value_i) : store_q[i];
    end
  end

  // Full store: drop the old top if it is larger, else the new value.
  assign discard = ge[DEPTH-1] ? store_q[DEPTH-1] : value_i;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd_i.insert && (CNT_W'(i) <= count_q)) begin
        store_q[i] <= new_val[i];
      end
    end
  end

  assign rd_addr = cmd_i.use_idx ? idx_q : cnt_m1[IDX_W-1:0];
  assign rd_data = store_q[rd_addr];

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert && !full) begin
      count_d = count_q + CNT_W'(1);
    end
    idx_d = idx_q;
    if (cmd_i.load_idx) begin
      idx_d = cnt_m2[IDX_W-1:0];
    end else if (cmd_i.dec_idx) begin
      idx_d = idx_q - IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    strobe_d = cmd_i.insert | cmd_i.emit_empty | cmd_i.emit_read;
    value_d  = '0;
    status_d = STAT_OK;
    last_d   = 1'b1;
    if (cmd_i.insert) begin
      if (full) begin
        value_d  = discard;
        status_d = STAT_FULL;
      end
    end else if (cmd_i.emit_empty) begin
      status_d = STAT_EMPTY;
    end else if (cmd_i.emit_read) begin
      value_d = rd_data;
      last_d  = cmd_i.read_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (strobe_d) begin
      value_q  <= value_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  assign stat_o.empty    = (count_q == '0);
  assign stat_o.single   = (count_q == CNT_W'(1));
  assign stat_o.idx_zero = (idx_q == '0);

  assign result_strobe_o = strobe_q;
  assign result_value_o  = value_q;
  assign status_o        = status_q;
  assign last_o          = last_q;

endmodule

// ===== hdl/bounded_sorted_insert_stack_top.sv =====
// Top level of the bounded sorted insert stack.
`timescale 1ns / 1ps
// Sorted stack of up to 16 signed 32-bit values, largest on top. Insert,
// peek and dump are taken when start_i is high and busy_o is low; every
// result beat appears on the result ports for one cycle with
// result_strobe_o high, starting the cycle after the item is taken, and
// the receiver cannot stall them. Insert, peek and empty reports keep
// busy_o low, so a new item may follow every cycle: the insert is done
// by a row of compare-and-shift cells, one comparator per entry. A dump
// of n entries gives one beat per cycle, busy_o high on every beat but
// the last, paced by the single read port over the cell row; the next
// item can be taken in the cycle the bottom entry is on the ports, and
// last_o marks that entry. A full insert keeps the 16 smallest values and
// reports the one it drops with status full. Command code 3 is accepted
// and dropped without a result.
module bounded_sorted_insert_stack_top import bsis_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   command_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic                         result_strobe_o,
  output logic signed [DATA_WIDTH-1:0] result_value_o,
  output logic [1:0]                   status_o,
  output logic                         last_o
);

  bsis_cmd_t  cmd;
  bsis_stat_t stat;

  // Decode items and step the dump sequence.
  bsis_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy_o    (busy_o)
  );

  // Hold the sorted cells and drive the result beat.
  bsis_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .value_i         (value_i),
    .stat_o          (stat),
    .result_strobe_o (result_strobe_o),
    .result_value_o  (result_value_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

endmodule

// ===== hdl/bsis_checker.sv =====
// Port-level checker for the sorted insert stack, bound to the top level.
`timescale 1ns / 1ps
`include "bounded_sorted_insert_stack_top_macros.svh"
module bsis_checker import bsis_pkg::*; (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic [1:0]                   command_i,
  input logic                         result_strobe_o,
  input logic [1:0]                   status_o,
  input logic                         last_o
);

  `BSIS_ASSERT_NEXT(a_dump_beats, busy_o, result_strobe_o, "dump beat missing")
  `BSIS_ASSERT_NOW(a_mid_dump_busy, result_strobe_o && !last_o, busy_o, "non-final beat idle")
  `BSIS_ASSERT_NOW(a_err_last, result_strobe_o && (status_o != STAT_OK), last_o, "status beat not final")
  `BSIS_ASSERT_NEXT(a_insert_beat, start_i && !busy_o && (command_i == CMD_INSERT), result_strobe_o && last_o, "insert beat missing")

endmodule

bind bounded_sorted_insert_stack_top bsis_checker u_bsis_checker (.*);
